// File: hw/rtl/hashed_page_table_map_unmap_macros.svh
// ----------------------------------------------------------------------------
// Hashed page table assertion macros
// Clocked concurrent assertion helpers; define ASSERT_OFF to compile them out.
// ----------------------------------------------------------------------------
`ifndef HASHED_PAGE_TABLE_MAP_UNMAP_MACROS_SVH
`define HASHED_PAGE_TABLE_MAP_UNMAP_MACROS_SVH

`ifndef ASSERT_OFF

// Same-cycle implication, checked on clk, muted while rst_n is low.
`define HPT_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("hpt assertion failed: same-cycle implication");

// Next-cycle implication, checked on clk, muted while rst_n is low.
`define HPT_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("hpt assertion failed: next-cycle implication");

`else

`define HPT_ASSERT_IMP(lbl, ante, cons)
`define HPT_ASSERT_NXT(lbl, ante, cons)

`endif

`endif

// File: hw/rtl/hpt_pkg.sv
// ----------------------------------------------------------------------------
// Hashed page table package
// Sizes, codes and small helper functions shared by the block and its
// channel interfaces.
// ----------------------------------------------------------------------------
`default_nettype none

package hpt_pkg;

  localparam int MAX_GROUPS      = 8192;
  localparam int SLOTS_PER_GROUP = 8;
  localparam int SEGMENT_ID_BITS = 36;
  localparam int PHYS_PAGE_BITS  = 32;

  localparam int PAGE_IDX_BITS = 16;
  localparam int HASH_BITS     = 39;
  localparam int ABBR_SHIFT    = 11;

  localparam int VPN_W      = PAGE_IDX_BITS + SEGMENT_ID_BITS;
  localparam int VPN_PORT_W = 52;
  localparam int PA_PORT_W  = 32;
  localparam int ABBR_W     = VPN_W - ABBR_SHIFT;
  localparam int TAG_W      = ABBR_W + 2;
  localparam int TRANS_W    = PHYS_PAGE_BITS + 2;

  localparam int SLOT_W      = $clog2(SLOTS_PER_GROUP);
  localparam int GRP_W       = $clog2(MAX_GROUPS);
  localparam int STORE_DEPTH = MAX_GROUPS * SLOTS_PER_GROUP;
  localparam int ADDR_W      = GRP_W + SLOT_W;
  localparam int SCAN_W      = SLOT_W + 1;           // primary and secondary groups
  localparam int SCAN_N      = 2 * SLOTS_PER_GROUP;
  localparam int SCNT_W      = SCAN_W + 1;           // holds SCAN_N itself

  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam int GIB_W      = 4;

  typedef enum logic {
    CMD_MAP   = 1'b0,
    CMD_UNMAP = 1'b1
  } cmd_t;

  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_NO_SPACE  = 2'd1,
    STAT_NOT_FOUND = 2'd2,
    STAT_NOT_READY = 2'd3
  } hpt_status_t;

  // Register select is paddr bit 2 (registers at byte 0 and byte 4).
  typedef enum logic {
    REG_TABLE_READY = 1'b0,
    REG_GROUP_BITS  = 1'b1
  } reg_sel_t;

  // Low bit of a tag entry is valid, next is the hash-select bit.
  localparam int TAG_VALID_BIT = 0;
  localparam int TAG_H_BIT     = 1;

  function automatic logic [HASH_BITS-1:0] page_hash(input logic [VPN_W-1:0] vpn);
    logic [HASH_BITS-1:0] hi;
    logic [HASH_BITS-1:0] lo;
    hi = HASH_BITS'(vpn[VPN_W-1:PAGE_IDX_BITS]);
    lo = HASH_BITS'(vpn[PAGE_IDX_BITS-1:0]);
    return hi ^ lo;
  endfunction

  // Mask with the low gib bits set, clipped to the store's group count.
  function automatic logic [GRP_W-1:0] group_mask(input logic [GIB_W-1:0] gib);
    logic [GRP_W-1:0] m;
    for (int i = 0; i < GRP_W; i++) begin
      m[i] = (i < int'(gib));
    end
    return m;
  endfunction

  // Lowest set bit of a slot mask.
  function automatic logic [SLOT_W-1:0] first_set(input logic [SLOTS_PER_GROUP-1:0] m);
    logic [SLOT_W-1:0] idx;
    idx = '0;
    for (int i = SLOTS_PER_GROUP - 1; i >= 0; i--) begin
      if (m[i]) begin
        idx = SLOT_W'(i);
      end
    end
    return idx;
  endfunction

endpackage

`default_nettype wire

// File: hw/rtl/hpt_req_if.sv
// ----------------------------------------------------------------------------
// Hashed page table request channel
// Valid/ready channel carrying one map or unmap request.
// ----------------------------------------------------------------------------
`default_nettype none

interface hpt_req_if;
  import hpt_pkg::*;

  logic                  valid;
  logic                  ready;
  cmd_t                  command;
  logic [VPN_PORT_W-1:0] virtual_page;
  logic [PA_PORT_W-1:0]  physical_page;
  logic                  writable;
  logic                  uncached;

  modport source (
    output valid, command, virtual_page, physical_page, writable, uncached,
    input  ready
  );

  modport sink (
    input  valid, command, virtual_page, physical_page, writable, uncached,
    output ready
  );
endinterface

`default_nettype wire

// File: hw/rtl/hpt_rsp_if.sv
// ----------------------------------------------------------------------------
// Hashed page table response channel
// Valid/ready channel carrying the outcome of one request.
// ----------------------------------------------------------------------------
`default_nettype none

interface hpt_rsp_if;
  import hpt_pkg::*;

  logic              valid;
  logic              ready;
  hpt_status_t       status;
  logic [SLOT_W-1:0] slot;
  logic              used_secondary;
  logic              replaced_old;

  modport source (
    output valid, status, slot, used_secondary, replaced_old,
    input  ready
  );

  modport sink (
    input  valid, status, slot, used_secondary, replaced_old,
    output ready
  );
endinterface

`default_nettype wire

// File: hw/rtl/hashed_page_table_map_unmap.sv
// ----------------------------------------------------------------------------
// Hashed page table map/unmap engine
// Keeps a table of 8-entry groups in a single-port tag memory and maps or
// unmaps one virtual page per request with a small sequencer.
// ----------------------------------------------------------------------------
//
//  Channel   Ports        Direction  Handshake / content
//  -------   ----------   ---------  ------------------------------------------
//  request   in_ch        sink       valid/ready; command, page, protection
//  response  out_ch       source     valid/ready; status, slot, group, replaced
//  config    cfg_*        APB slave  table_ready at 0x0, group_index_bits at 0x4
//
//  A map or unmap request runs from accept to response as 16 tag memory
//  reads (one per cycle, eight slots of each group), a registered read
//  stage, a decision state, up to two tag writes (drop a match, fill a
//  slot), and the response. Reads and writes share the single tag memory
//  port; the input is ready again in the cycle after the response is loaded.
//  A request that arrives while the table is not ready goes straight to
//  the response state without reading the tag memory.
//  After reset the tag memory is swept once, one entry per cycle over all
//  65536 entries; no request is accepted meanwhile, config writes still land.
//  A finished response waits in the output register; a new request may be
//  accepted while it waits.
// ----------------------------------------------------------------------------
`default_nettype none

`include "hashed_page_table_map_unmap_macros.svh"

module hashed_page_table_map_unmap (
  input  logic                           clk,
  input  logic                           rst_n,
  hpt_req_if.sink                        in_ch,
  hpt_rsp_if.source                      out_ch,
  input  logic                           cfg_psel,
  input  logic                           cfg_penable,
  input  logic                           cfg_pwrite,
  input  logic [hpt_pkg::CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [hpt_pkg::CFG_DATA_W-1:0] cfg_pwdata,
  output logic [hpt_pkg::CFG_DATA_W-1:0] cfg_prdata,
  output logic                           cfg_pready
);
  import hpt_pkg::*;

  // Sequencer states, one-hot.
  typedef enum logic [6:0] {
    S_CLEAR  = 7'b0000001,
    S_IDLE   = 7'b0000010,
    S_READ   = 7'b0000100,
    S_DECIDE = 7'b0001000,
    S_INVAL  = 7'b0010000,
    S_FILL   = 7'b0100000,
    S_RESP   = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic             table_ready_r;
  logic [GIB_W-1:0] gib_r;
  logic             cfg_wr;
  reg_sel_t         cfg_sel;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_sel    = reg_sel_t'(cfg_paddr[2]);

  always_comb begin
    unique case (cfg_sel)
      REG_TABLE_READY: cfg_prdata = CFG_DATA_W'(table_ready_r);
      REG_GROUP_BITS:  cfg_prdata = CFG_DATA_W'(gib_r);
      default:         cfg_prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      table_ready_r <= 1'b0;
      gib_r         <= GIB_W'(11);
    end else if (cfg_wr) begin
      unique case (cfg_sel)
        REG_TABLE_READY: table_ready_r <= cfg_pwdata[0];
        REG_GROUP_BITS:  gib_r         <= cfg_pwdata[GIB_W-1:0];
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Request capture
  // --------------------------------------------------------------------------
  logic                 in_fire;
  logic [VPN_W-1:0]     vpn;
  logic [HASH_BITS-1:0] hash;
  logic [GRP_W-1:0]     gmask;

  cmd_t                     cmd_r;
  logic [ABBR_W-1:0]        abbr_r;
  logic [GRP_W-1:0]         pgrp_r;
  logic [GRP_W-1:0]         sgrp_r;
  logic [TRANS_W-1:0]       trans_r;

  assign in_ch.ready = (state_r == S_IDLE);
  assign in_fire     = in_ch.valid && in_ch.ready;

  assign vpn   = in_ch.virtual_page[VPN_W-1:0];
  assign hash  = page_hash(vpn);
  assign gmask = group_mask(gib_r);

  always_ff @(posedge clk) begin
    if (in_fire) begin
      cmd_r   <= in_ch.command;
      abbr_r  <= vpn[VPN_W-1:ABBR_SHIFT];
      pgrp_r  <= hash[GRP_W-1:0] & gmask;
      sgrp_r  <= ~hash[GRP_W-1:0] & gmask;
      trans_r <= {in_ch.uncached, in_ch.writable,
                  in_ch.physical_page[PHYS_PAGE_BITS-1:0]};
    end
  end

  // --------------------------------------------------------------------------
  // Tag and translation memories, one shared port
  // --------------------------------------------------------------------------
  logic [TAG_W-1:0]   tag_mem [STORE_DEPTH];
  logic [TRANS_W-1:0] trans_mem [STORE_DEPTH];

  logic [ADDR_W-1:0] clr_cnt_r;
  logic [SCNT_W-1:0] scan_cnt_r;
  logic [ADDR_W-1:0] inv_addr_r;
  logic [ADDR_W-1:0] fill_addr_r;
  logic              fill_sec_r;

  logic [ADDR_W-1:0] mem_addr;
  logic              tag_we;
  logic [TAG_W-1:0]  tag_wdata;
  logic [TAG_W-1:0]  rdata_r;

  logic [SCAN_W-1:0] scan_idx;
  logic [GRP_W-1:0]  scan_grp;

  assign scan_idx = scan_cnt_r[SCAN_W-1:0];
  assign scan_grp = scan_idx[SCAN_W-1] ? sgrp_r : pgrp_r;

  always_comb begin
    mem_addr  = {scan_grp, scan_idx[SLOT_W-1:0]};
    tag_we    = 1'b0;
    tag_wdata = '0;
    priority case (1'b1)
      state_r[0]: begin   // clear sweep
        mem_addr = clr_cnt_r;
        tag_we   = 1'b1;
      end
      state_r[4]: begin   // invalidate the matching entry
        mem_addr = inv_addr_r;
        tag_we   = 1'b1;
      end
      state_r[5]: begin   // fill the chosen free slot
        mem_addr  = fill_addr_r;
        tag_we    = 1'b1;
        tag_wdata = {abbr_r, fill_sec_r, 1'b1};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (tag_we) begin
      tag_mem[mem_addr] <= tag_wdata;
    end
    rdata_r <= tag_mem[mem_addr];
  end

  always_ff @(posedge clk) begin
    if (state_r == S_FILL) begin
      trans_mem[fill_addr_r] <= trans_r;
    end
  end

  // --------------------------------------------------------------------------
  // Slot scan: one tag compare per cycle, collected into match/free masks
  // --------------------------------------------------------------------------
  logic              rd_pend_r;
  logic [SCAN_W-1:0] rd_idx_r;
  logic [SCAN_N-1:0] match_r;
  logic [SCAN_N-1:0] free_r;
  logic              tag_hit;

  assign tag_hit = rdata_r[TAG_VALID_BIT] &&
                   (rdata_r[TAG_W-1:1] == {abbr_r, rd_idx_r[SCAN_W-1]});

  always_ff @(posedge clk) begin
    if (in_fire) begin
      match_r <= '0;
      free_r  <= '0;
    end else if (rd_pend_r) begin
      match_r[rd_idx_r] <= tag_hit;
      free_r[rd_idx_r]  <= !rdata_r[TAG_VALID_BIT];
    end
  end

  // --------------------------------------------------------------------------
  // Decision: pick the match to drop and the slot to fill
  // --------------------------------------------------------------------------
  logic [SLOTS_PER_GROUP-1:0] mp, ms, fp, fs, mslot_oh;
  logic                       hit_p, hit, msec, fsec, any_free;
  logic [SLOT_W-1:0]          mslot, fslot;
  logic [GRP_W-1:0]           mgrp;

  always_comb begin
    mp       = match_r[SLOTS_PER_GROUP-1:0];
    ms       = match_r[SCAN_N-1:SLOTS_PER_GROUP];
    hit_p    = |mp;
    hit      = hit_p || (|ms);
    msec     = !hit_p;
    mslot    = first_set(hit_p ? mp : ms);
    mgrp     = msec ? sgrp_r : pgrp_r;
    mslot_oh = SLOTS_PER_GROUP'(1) << mslot;
    // A dropped match frees its slot for the fill; both groups may coincide.
    fp = free_r[SLOTS_PER_GROUP-1:0];
    fs = free_r[SCAN_N-1:SLOTS_PER_GROUP];
    if (hit && (mgrp == pgrp_r)) begin
      fp = fp | mslot_oh;
    end
    if (hit && (mgrp == sgrp_r)) begin
      fs = fs | mslot_oh;
    end
    fsec     = !(|fp);
    fslot    = first_set(fsec ? fs : fp);
    any_free = (|fp) || (|fs);
  end

  // --------------------------------------------------------------------------
  // Result holding and sequencer
  // --------------------------------------------------------------------------
  hpt_status_t       res_status_r;
  logic [SLOT_W-1:0] res_slot_r;
  logic              res_sec_r;
  logic              res_repl_r;
  logic              out_free;

  logic              out_valid_r;
  hpt_status_t       out_status_r;
  logic [SLOT_W-1:0] out_slot_r;
  logic              out_sec_r;
  logic              out_repl_r;

  assign out_free = !out_valid_r || out_ch.ready;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_CLEAR:  if (&clr_cnt_r) state_nxt = S_IDLE;
      S_IDLE:   if (in_fire) state_nxt = table_ready_r ? S_READ : S_RESP;
      S_READ:   if (scan_cnt_r == SCNT_W'(SCAN_N)) state_nxt = S_DECIDE;
      S_DECIDE: begin
        if (!hit && ((cmd_r == CMD_UNMAP) || !any_free)) begin
          state_nxt = S_RESP;
        end else if (hit) begin
          state_nxt = S_INVAL;
        end else begin
          state_nxt = S_FILL;
        end
      end
      S_INVAL:  state_nxt = (cmd_r == CMD_UNMAP) ? S_RESP : S_FILL;
      S_FILL:   state_nxt = S_RESP;
      S_RESP:   if (out_free) state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_cnt_r   <= '0;
      scan_cnt_r  <= '0;
      rd_pend_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_CLEAR) begin
        clr_cnt_r <= clr_cnt_r + ADDR_W'(1);
      end
      // Advance the scan; issue reads until every slot of both groups is out.
      if (in_fire) begin
        scan_cnt_r <= '0;
      end else if (state_r == S_READ) begin
        scan_cnt_r <= scan_cnt_r + SCNT_W'(1);
      end
      rd_pend_r <= (state_r == S_READ) && (scan_cnt_r != SCNT_W'(SCAN_N));
      if ((state_r == S_RESP) && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload.
  always_ff @(posedge clk) begin
    rd_idx_r <= scan_idx;
    if (in_fire) begin
      res_status_r <= table_ready_r ? STAT_OK : STAT_NOT_READY;
      res_slot_r   <= '0;
      res_sec_r    <= 1'b0;
      res_repl_r   <= 1'b0;
    end
    if (state_r == S_DECIDE) begin
      inv_addr_r  <= {mgrp, mslot};
      fill_addr_r <= {fsec ? sgrp_r : pgrp_r, fslot};
      fill_sec_r  <= fsec;
      if (cmd_r == CMD_UNMAP) begin
        if (hit) begin
          res_slot_r <= mslot;
          res_sec_r  <= msec;
        end else begin
          res_status_r <= STAT_NOT_FOUND;
        end
      end else begin
        if (any_free) begin
          res_slot_r <= fslot;
          res_sec_r  <= fsec;
          res_repl_r <= hit;
        end else begin
          res_status_r <= STAT_NO_SPACE;
        end
      end
    end
    // Load the output register once it is free; hold it otherwise.
    if ((state_r == S_RESP) && out_free) begin
      out_status_r <= res_status_r;
      out_slot_r   <= res_slot_r;
      out_sec_r    <= res_sec_r;
      out_repl_r   <= res_repl_r;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.status         = out_status_r;
  assign out_ch.slot           = out_slot_r;
  assign out_ch.used_secondary = out_sec_r;
  assign out_ch.replaced_old   = out_repl_r;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  // The fill always targets one of the two groups of the request.
  `HPT_ASSERT_IMP(a_fill_in_group, state_r == S_FILL, (fill_addr_r[ADDR_W-1:SLOT_W] == pgrp_r) || (fill_addr_r[ADDR_W-1:SLOT_W] == sgrp_r))
  // A request with the table not ready skips the memory entirely.
  `HPT_ASSERT_NXT(a_not_ready_resp, in_fire && !table_ready_r, state_r == S_RESP)
  // A full table never reports a replaced mapping.
  `HPT_ASSERT_IMP(a_no_space_clean, out_valid_r && (out_status_r == STAT_NO_SPACE), !out_repl_r)
  // The scan counter never runs past the last issued read.
  `HPT_ASSERT_IMP(a_scan_bound, state_r == S_READ, scan_cnt_r <= SCNT_W'(SCAN_N))

endmodule

`default_nettype wire

// File: tb/sv/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Hashed page table map/unmap testbench
// Feeds map and unmap requests through the valid/ready request channel,
// predicts each response from a private copy of the tag table, and checks
// every response field in order. Runs under several table settings with
// random sender gaps, receiver stalls and one long output hold-off.
// ----------------------------------------------------------------------------

module tb;
  import hpt_pkg::*;

  // Longest output hold-off; the block must back up and stall its input.
  localparam int LONG_HOLD      = 400;
  // Longest correct stretch without a handshake is the tag sweep after
  // reset; the limit is set well above it.
  localparam int WATCHDOG_LIMIT = 200000;
  // Idle settling time after the last response.
  localparam int DRAIN_CYCLES   = 60;
  localparam int SHOWN_ERRORS   = 10;

  typedef struct packed {
    cmd_t                  command;
    logic [VPN_PORT_W-1:0] virtual_page;
    logic [PA_PORT_W-1:0]  physical_page;
    logic                  writable;
    logic                  uncached;
  } page_req_t;

  typedef struct packed {
    hpt_status_t       status;
    logic [SLOT_W-1:0] slot;
    logic              used_secondary;
    logic              replaced_old;
  } page_rsp_t;

  logic clk;
  logic rst_n;

  logic                  cfg_psel;
  logic                  cfg_penable;
  logic                  cfg_pwrite;
  logic [CFG_ADDR_W-1:0] cfg_paddr;
  logic [CFG_DATA_W-1:0] cfg_pwdata;
  logic [CFG_DATA_W-1:0] cfg_prdata;
  logic                  cfg_pready;

  hpt_req_if req_ch ();
  hpt_rsp_if rsp_ch ();

  hashed_page_table_map_unmap dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (req_ch),
    .out_ch      (rsp_ch),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  // Clock: 4 ns period.
  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // --------------------------------------------------------------------------
  // Predictor state: our own tag table and register copies.
  // Translation entries never reach a response, so they are not kept.
  // --------------------------------------------------------------------------
  bit   [TAG_W-1:0] page_tags [STORE_DEPTH];
  logic             cfg_table_ready;
  logic [GIB_W-1:0] cfg_group_bits;

  page_req_t        pending_reqs [$];   // requests waiting for the driver
  page_rsp_t        expected_rsps [$];  // predicted responses, oldest first
  logic [VPN_PORT_W-1:0] hot_pages [$]; // pages crowding a few groups

  int queued_reqs;
  int accepted_reqs;
  int rsp_seen;
  int failures;
  int stat_seen [4];

  int sender_idle_pct;
  int recv_stall_pct;
  int hold_requests;
  int hold_seen;
  int hold_left;
  int idle_cycles;

  // Group mask in use: low group_bits bits, clipped to the store size.
  function automatic int unsigned group_mask_now();
    return ((32'd1 << cfg_group_bits) - 1) & (MAX_GROUPS - 1);
  endfunction

  function automatic int unsigned slot_base(logic [HASH_BITS-1:0] h);
    return (int'(h) & group_mask_now()) * SLOTS_PER_GROUP;
  endfunction

  // Slot of a valid entry whose tag (valid bit cleared) equals want, or -1.
  function automatic int find_entry(int unsigned base, logic [TAG_W-1:0] want);
    logic [TAG_W-1:0] t;
    for (int i = 0; i < SLOTS_PER_GROUP; i++) begin
      t = page_tags[base + i];
      if (t[TAG_VALID_BIT] && {t[TAG_W-1:1], 1'b0} == want) begin
        return i;
      end
    end
    return -1;
  endfunction

  function automatic int find_free(int unsigned base);
    for (int i = 0; i < SLOTS_PER_GROUP; i++) begin
      if (!page_tags[base + i][TAG_VALID_BIT]) begin
        return i;
      end
    end
    return -1;
  endfunction

  // Apply one request to the table copy and return the response it earns.
  function automatic page_rsp_t predict_page_op(page_req_t r);
    page_rsp_t            o;
    logic [HASH_BITS-1:0] h;
    logic [TAG_W-1:0]     abbr;
    int unsigned          pbase;
    int unsigned          sbase;
    int                   s;
    logic                 sec;
    o = '{status: STAT_OK, slot: '0, used_secondary: 1'b0, replaced_old: 1'b0};
    if (!cfg_table_ready) begin
      o.status = STAT_NOT_READY;
      return o;
    end
    h     = HASH_BITS'(r.virtual_page[VPN_PORT_W-1:PAGE_IDX_BITS])
          ^ HASH_BITS'(r.virtual_page[PAGE_IDX_BITS-1:0]);
    abbr  = {r.virtual_page[VPN_PORT_W-1:ABBR_SHIFT], 2'b00};
    pbase = slot_base(h);
    sbase = slot_base(~h);
    // Hash-select bit must agree with the group being searched.
    sec = 1'b0;
    s   = find_entry(pbase, abbr);
    if (s < 0) begin
      s   = find_entry(sbase, abbr | TAG_W'(1 << TAG_H_BIT));
      sec = 1'b1;
    end
    if (r.command == CMD_UNMAP) begin
      if (s < 0) begin
        o.status = STAT_NOT_FOUND;
        return o;
      end
      page_tags[(sec ? sbase : pbase) + s][TAG_VALID_BIT] = 1'b0;
      o.slot           = SLOT_W'(s);
      o.used_secondary = sec;
      return o;
    end
    if (s >= 0) begin
      page_tags[(sec ? sbase : pbase) + s][TAG_VALID_BIT] = 1'b0;
      o.replaced_old = 1'b1;
    end
    sec = 1'b0;
    s   = find_free(pbase);
    if (s < 0) begin
      s   = find_free(sbase);
      sec = 1'b1;
    end
    if (s < 0) begin
      o.status       = STAT_NO_SPACE;
      o.replaced_old = 1'b0;
      return o;
    end
    page_tags[(sec ? sbase : pbase) + s] = abbr | (TAG_W'(sec) << TAG_H_BIT) | TAG_W'(1);
    o.slot           = SLOT_W'(s);
    o.used_secondary = sec;
    return o;
  endfunction

  // --------------------------------------------------------------------------
  // Driver: offer queued requests, idle at random, hold until accepted.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      req_ch.valid <= 1'b0;
    end else begin
      // Predict on the request taken at this edge, before it changes.
      if (req_ch.valid && req_ch.ready) begin
        expected_rsps.push_back(predict_page_op('{command:       req_ch.command,
                                                  virtual_page:  req_ch.virtual_page,
                                                  physical_page: req_ch.physical_page,
                                                  writable:      req_ch.writable,
                                                  uncached:      req_ch.uncached}));
        accepted_reqs++;
      end
      // Advance only when the slot is empty or was just taken.
      if (!req_ch.valid || req_ch.ready) begin
        if (pending_reqs.size() > 0 && $urandom_range(99) >= sender_idle_pct) begin
          page_req_t nxt;
          nxt = pending_reqs.pop_front();
          req_ch.valid         <= 1'b1;
          req_ch.command       <= nxt.command;
          req_ch.virtual_page  <= nxt.virtual_page;
          req_ch.physical_page <= nxt.physical_page;
          req_ch.writable      <= nxt.writable;
          req_ch.uncached      <= nxt.uncached;
        end else begin
          req_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: random stalls, plus a long hold-off on request.
  always @(posedge clk) begin
    if (!rst_n) begin
      rsp_ch.ready <= 1'b0;
    end else if (hold_seen != hold_requests) begin
      hold_seen    <= hold_requests;
      hold_left    <= LONG_HOLD;
      rsp_ch.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left    <= hold_left - 1;
      rsp_ch.ready <= 1'b0;
    end else begin
      rsp_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: check each response against the oldest prediction; watchdog.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n && rsp_ch.valid && rsp_ch.ready) begin
      page_rsp_t want;
      rsp_seen++;
      stat_seen[rsp_ch.status]++;
      if (expected_rsps.size() == 0) begin
        failures++;
        if (failures <= SHOWN_ERRORS) begin
          $display("tb: unexpected response status=%0d slot=%0d sec=%0b repl=%0b",
                   rsp_ch.status, rsp_ch.slot, rsp_ch.used_secondary,
                   rsp_ch.replaced_old);
        end
      end else begin
        want = expected_rsps.pop_front();
        if (rsp_ch.status !== want.status || rsp_ch.slot !== want.slot ||
            rsp_ch.used_secondary !== want.used_secondary ||
            rsp_ch.replaced_old !== want.replaced_old) begin
          failures++;
          if (failures <= SHOWN_ERRORS) begin
            $display("tb: response %0d mismatch: exp st=%0d slot=%0d sec=%0b repl=%0b",
                     rsp_seen, want.status, want.slot, want.used_secondary,
                     want.replaced_old);
            $display("tb:                     got st=%0d slot=%0d sec=%0b repl=%0b",
                     rsp_ch.status, rsp_ch.slot, rsp_ch.used_secondary,
                     rsp_ch.replaced_old);
          end
        end
      end
    end
    if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("tb: watchdog expired after %0d idle cycles", idle_cycles);
        $display("tb: failure");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers.
  // --------------------------------------------------------------------------
  task automatic cfg_write(reg_sel_t sel, logic [CFG_DATA_W-1:0] value);
    // Setup cycle, then access cycle; the register lands at the edge after.
    @(posedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {sel, 2'b00};
    cfg_pwdata  <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    if (sel == REG_TABLE_READY) begin
      cfg_table_ready = value[0];
    end else begin
      cfg_group_bits = value[GIB_W-1:0];
    end
  endtask

  task automatic push_req(cmd_t c, logic [VPN_PORT_W-1:0] vpn, logic [PA_PORT_W-1:0] pa,
                          logic wr, logic unc);
    pending_reqs.push_back('{command: c, virtual_page: vpn, physical_page: pa,
                             writable: wr, uncached: unc});
    queued_reqs++;
  endtask

  // Wait for every response, then let the block settle.
  task automatic wait_drained();
    wait (rsp_seen == queued_reqs && accepted_reqs == queued_reqs);
    repeat (DRAIN_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  // Random page whose primary group under the current mask is grp.
  function automatic logic [VPN_PORT_W-1:0] vpn_in_group(int unsigned grp);
    logic [SEGMENT_ID_BITS-1:0] seg;
    logic [PAGE_IDX_BITS-1:0]   m16;
    logic [PAGE_IDX_BITS-1:0]   target;
    seg    = SEGMENT_ID_BITS'({$urandom, $urandom});
    m16    = PAGE_IDX_BITS'(group_mask_now());
    target = (PAGE_IDX_BITS'($urandom) & ~m16) | (PAGE_IDX_BITS'(grp) & m16);
    return {seg, seg[PAGE_IDX_BITS-1:0] ^ target};
  endfunction

  // Crowd two group pairs so groups fill up, overflow and get freed again.
  task automatic build_hot_pages();
    int unsigned mask;
    int unsigned g;
    logic [VPN_PORT_W-1:0] v;
    hot_pages.delete();
    mask = group_mask_now();
    for (int k = 0; k < 2; k++) begin
      g = $urandom_range(mask);
      for (int i = 0; i < 12; i++) begin
        v = vpn_in_group(g);
        hot_pages.push_back(v);
        // With an 11-bit mask, flipping the low 11 bits keeps the short
        // page number but swaps primary and secondary: exercises the
        // hash-select check.
        if (cfg_group_bits == 4'd11 && i < 3) begin
          hot_pages.push_back(v ^ VPN_PORT_W'(12'h7ff));
        end
      end
      for (int i = 0; i < 5; i++) begin
        hot_pages.push_back(vpn_in_group(~g & mask));
      end
    end
  endtask

  task automatic push_random_reqs(int n);
    int pick;
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(99);
      if (pick < 55) begin
        push_req(CMD_MAP, hot_pages[$urandom_range(hot_pages.size() - 1)],
                 $urandom, 1'($urandom), 1'($urandom));
      end else if (pick < 85) begin
        push_req(CMD_UNMAP, hot_pages[$urandom_range(hot_pages.size() - 1)],
                 $urandom, 1'($urandom), 1'($urandom));
      end else begin
        // Noise: any page, any command.
        push_req(cmd_t'($urandom_range(1)), VPN_PORT_W'({$urandom, $urandom}),
                 $urandom, 1'($urandom), 1'($urandom));
      end
    end
  endtask

  task automatic run_phase(logic ready_val, logic [GIB_W-1:0] gib, int s_idle, int r_idle,
                           int n, bit long_hold);
    // Upper data bits are don't-care; scramble them.
    cfg_write(REG_TABLE_READY, {31'($urandom), ready_val});
    cfg_write(REG_GROUP_BITS, {28'($urandom), gib});
    build_hot_pages();
    @(negedge clk);
    sender_idle_pct = s_idle;
    recv_stall_pct  = r_idle;
    if (long_hold) begin
      hold_requests++;
    end
    push_random_reqs(n);
    wait_drained();
  endtask

  // --------------------------------------------------------------------------
  // Main sequence.
  // --------------------------------------------------------------------------
  initial begin
    int unsigned fill_grp;
    logic [VPN_PORT_W-1:0] fill_pages [17];

    rst_n              = 1'b0;
    req_ch.valid         = 1'b0;
    req_ch.command       = CMD_MAP;
    req_ch.virtual_page  = '0;
    req_ch.physical_page = '0;
    req_ch.writable      = 1'b0;
    req_ch.uncached      = 1'b0;
    rsp_ch.ready       = 1'b0;
    cfg_psel           = 1'b0;
    cfg_penable        = 1'b0;
    cfg_pwrite         = 1'b0;
    cfg_paddr          = '0;
    cfg_pwdata         = '0;
    cfg_table_ready    = 1'b0;
    cfg_group_bits     = 4'd11;
    queued_reqs        = 0;
    accepted_reqs      = 0;
    rsp_seen           = 0;
    failures           = 0;
    stat_seen          = '{default: 0};
    sender_idle_pct    = 0;
    recv_stall_pct     = 0;
    hold_requests      = 0;
    hold_seen          = 0;
    hold_left          = 0;
    idle_cycles        = 0;

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: table not ready yet, so both requests bounce.
    push_req(CMD_MAP, '1, '1, 1'b1, 1'b1);
    push_req(CMD_UNMAP, '0, '0, 1'b0, 1'b0);
    wait_drained();

    cfg_write(REG_TABLE_READY, 32'd1);
    cfg_write(REG_GROUP_BITS, 32'd11);
    @(negedge clk);
    // Unmap of an absent page, map, remap over itself, unmap, extremes.
    push_req(CMD_UNMAP, '0, $urandom, 1'b0, 1'b0);
    push_req(CMD_MAP, '0, '0, 1'b0, 1'b0);
    push_req(CMD_MAP, '0, '1, 1'b1, 1'b1);
    push_req(CMD_UNMAP, '0, '0, 1'b1, 1'b0);
    push_req(CMD_MAP, '1, '1, 1'b0, 1'b1);
    // Fill a primary group and its secondary, then overflow.
    // Avoid group 0 and its complement, which hold the pages above.
    fill_grp = $urandom_range(1, 2046);
    for (int i = 0; i < 17; i++) begin
      fill_pages[i] = vpn_in_group(fill_grp);
      push_req(CMD_MAP, fill_pages[i], $urandom, 1'($urandom), 1'($urandom));
    end
    // Drop one that went to the secondary group.
    push_req(CMD_UNMAP, fill_pages[12], '0, 1'b0, 1'b0);
    wait_drained();

    // Random phases over table sizes, idle patterns and readiness.
    run_phase(1'b1, 4'd11, 0, 0, 150, 1'b1);
    run_phase(1'b1, 4'd13, 48, 0, 130, 1'b0);
    run_phase(1'b1, 4'd12, 0, 48, 130, 1'b0);
    run_phase(1'b1, 4'd15, 15, 15, 130, 1'b0);   // oversized group bits
    run_phase(1'b0, 4'd11, 15, 15, 20, 1'b0);    // table not ready
    run_phase(1'b1, 4'd11, 0, 0, 65, 1'b0);

    if (expected_rsps.size() != 0) begin
      failures++;
      $display("tb: %0d predicted responses never arrived", expected_rsps.size());
    end
    $display("tb: %0d requests at group bits 11/12/13/15 and not ready, %0d mismatches",
             accepted_reqs, failures);
    $display("tb: responses ok %0d, no space %0d, not found %0d, not ready %0d",
             stat_seen[STAT_OK], stat_seen[STAT_NO_SPACE], stat_seen[STAT_NOT_FOUND],
             stat_seen[STAT_NOT_READY]);
    if (failures == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
